// File: hw/rtl/nbody_gravity_euler_step_unit_defines.svh
// Assertion macros for the n-body step unit.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef NBODY_GRAVITY_EULER_STEP_UNIT_DEFINES_SVH
`define NBODY_GRAVITY_EULER_STEP_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NGS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NGS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NGS_ASSERT_IMP(lbl, ante, cons)
`define NGS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/ngs_pkg.sv
// Shared types, codes and helpers of the n-body step unit.
// No dependencies.
package ngs_pkg;

    localparam logic [1:0] CFG_GAIN = 2'd0;
    localparam logic [1:0] CFG_STEP = 2'd1;
    localparam logic [1:0] CFG_SOFT = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [15:0] GAIN_RST = 16'd7680;
    localparam logic [15:0] STEP_RST = 16'd1092;
    localparam logic [30:0] SOFT_RST = 31'd6554;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 65;

    typedef logic [2:0][31:0] t_vec;

    typedef struct packed {
        logic go;
        logic is_sqrt;
    } t_du_req;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_RDI   = 20'h00002,
        S_RDJ   = 20'h00004,
        S_SQR   = 20'h00008,
        S_ACC   = 20'h00010,
        S_SQRT  = 20'h00020,
        S_RMUL  = 20'h00040,
        S_CMULH = 20'h00080,
        S_CMULL = 20'h00100,
        S_CUBE  = 20'h00200,
        S_DEN   = 20'h00400,
        S_GM    = 20'h00800,
        S_NUM   = 20'h01000,
        S_DIV   = 20'h02000,
        S_FACC  = 20'h04000,
        S_NEXTJ = 20'h08000,
        S_VMUL  = 20'h10000,
        S_VADD  = 20'h20000,
        S_PMUL  = 20'h40000,
        S_PADD  = 20'h80000
    } t_state;

    function automatic logic signed [31:0] axis_get(input t_vec v, input logic [1:0] a);
        logic signed [31:0] r;
        case (a)
            2'd0:    r = v[0];
            2'd1:    r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    function automatic t_vec axis_put(input t_vec v, input logic [1:0] a,
                                      input logic [31:0] x);
        t_vec r;
        r = v;
        case (a)
            2'd0:    r[0] = x;
            2'd1:    r[1] = x;
            default: r[2] = x;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > 56'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -56'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ngs_rdiv.sv
// Shared iterative root and divide unit: restoring square root or long division.
// Depends on ngs_pkg.
module ngs_rdiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ngs_pkg::t_du_req i_req,
    input  logic [64:0]      i_opa,
    input  logic [63:0]      i_den,
    output logic             o_done,
    output logic [64:0]      o_res
);
    logic        r_busy;
    logic        r_sqrt;
    logic [6:0]  r_cnt;
    logic [64:0] r_src;
    logic [65:0] r_rem;
    logic [64:0] r_res;
    logic        r_done;

    logic [65:0] n_cand;
    logic [65:0] n_sub;
    logic        n_ge;

    always_comb begin
        if (r_sqrt) begin
            n_cand = {r_rem[63:0], r_src[64:63]};
            n_sub  = {r_res[63:0], 2'b01};
        end else begin
            n_cand = {r_rem[64:0], r_src[64]};
            n_sub  = {2'b00, i_den};
        end
        n_ge = (n_cand >= n_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_sqrt <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_cnt  <= i_req.is_sqrt ? 7'(ngs_pkg::SQRT_STEPS) : 7'(ngs_pkg::DIV_STEPS);
                r_src  <= i_opa;
                r_rem  <= '0;
                r_res  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_ge ? (n_cand - n_sub) : n_cand;
                r_res  <= {r_res[63:0], n_ge};
                r_src  <= r_sqrt ? {r_src[62:0], 2'b00} : {r_src[63:0], 1'b0};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// File: hw/rtl/nbody_gravity_euler_step_unit.sv
// Top level of the softened n-body semi-implicit Euler step unit.
// Depends on ngs_pkg, ngs_rdiv and nbody_gravity_euler_step_unit_defines.svh.
// A load item gives no result. A tick item spends most of its time in the
// shared root/divide unit: 32 steps for the distance root and 65 steps for
// each of the three axis divisions of every pair (skipped when the
// denominator is zero). busy stays high for the whole tick; the BODIES
// results then come out on consecutive cycles with o_strobe high and must be
// taken as they appear.
`include "nbody_gravity_euler_step_unit_defines.svh"
module nbody_gravity_euler_step_unit #(
    parameter int BODIES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [1:0]         i_body,
    input  logic signed [31:0] i_load_x,
    input  logic signed [31:0] i_load_y,
    input  logic signed [31:0] i_load_z,
    input  logic signed [31:0] i_load_vx,
    input  logic signed [31:0] i_load_vy,
    input  logic signed [31:0] i_load_vz,
    input  logic [15:0]        i_load_mass,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [1:0]         o_out_body,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_z,
    output logic               o_last_body
);
    localparam int IW = (BODIES > 2) ? $clog2(BODIES) : 1;
    localparam logic [IW-1:0] ILAST = IW'(BODIES - 1);

    ngs_pkg::t_state    r_state;
    ngs_pkg::t_vec      r_pos [BODIES];
    ngs_pkg::t_vec      r_vel [BODIES];
    ngs_pkg::t_vec      r_np  [BODIES];
    logic [15:0]        r_wt  [BODIES];
    logic signed [32:0] r_d   [3];
    logic signed [31:0] r_f   [3];

    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic [1:0]         r_ax;
    logic signed [31:0] r_tmp;
    logic [63:0]        r_r2;
    logic [31:0]        r_r;
    logic [15:0]        r_sl;
    logic [63:0]        r_cacc;
    logic [62:0]        r_cube;
    logic [63:0]        r_den;
    logic [31:0]        r_gm;
    logic signed [31:0] r_v;
    logic signed [67:0] r_prod;
    logic               r_go;
    logic               r_is_sqrt;
    logic [15:0]        r_gain;
    logic [15:0]        r_ts;
    logic [30:0]        r_soft;

    logic               r_strobe;
    logic [1:0]         r_obody;
    ngs_pkg::t_vec      r_ovec;
    logic               r_olast;
    logic               r_emit;

    logic [IW-1:0]      n_pidx;
    ngs_pkg::t_vec      n_prd;
    logic signed [31:0] n_pax;
    logic signed [31:0] n_vax;
    logic signed [33:0] n_ma;
    logic signed [33:0] n_mb;
    logic signed [67:0] n_mul;
    logic signed [32:0] n_dax;
    logic [31:0]        n_abs;
    logic [64:0]        n_r2s;
    logic [64:0]        n_cube;
    logic [32:0]        n_mag;
    logic signed [55:0] n_fsum;
    logic signed [55:0] n_vsum;
    logic signed [55:0] n_psum;
    logic signed [31:0] n_vnew;
    logic [IW:0]        n_j1;
    logic [IW:0]        n_j2;
    logic [IW+1:0]      n_iext;
    logic [IW-1:0]      n_lidx;
    logic               du_done;
    logic [64:0]        du_res;
    ngs_pkg::t_du_req   du_req;

    always_comb begin
        n_pidx = (r_state == ngs_pkg::S_RDJ) ? r_j : r_i;
        n_prd  = r_pos[n_pidx];
        n_pax  = ngs_pkg::axis_get(n_prd, r_ax);
        n_vax  = ngs_pkg::axis_get(r_vel[r_i], r_ax);
        case (r_ax)
            2'd0:    n_dax = r_d[0];
            2'd1:    n_dax = r_d[1];
            default: n_dax = r_d[2];
        endcase
        n_abs = n_dax[32] ? 32'(-n_dax) : n_dax[31:0];

        case (r_state)
            ngs_pkg::S_SQR: begin
                n_ma = {n_dax[32], n_dax};
                n_mb = {n_dax[32], n_dax};
            end
            ngs_pkg::S_RMUL: begin
                n_ma = {2'b00, r_r};
                n_mb = {2'b00, r_r};
            end
            ngs_pkg::S_CMULH: begin
                n_ma = {2'b00, r_prod[63:32]};
                n_mb = {2'b00, r_r};
            end
            ngs_pkg::S_CMULL: begin
                n_ma = {18'b0, r_sl};
                n_mb = {2'b00, r_r};
            end
            ngs_pkg::S_GM: begin
                n_ma = {18'b0, r_gain};
                n_mb = {18'b0, r_wt[r_j]};
            end
            ngs_pkg::S_NUM: begin
                n_ma = {2'b00, n_abs};
                n_mb = {2'b00, r_gm};
            end
            ngs_pkg::S_VMUL: begin
                n_ma = {{2{r_f[r_ax][31]}}, r_f[r_ax]};
                n_mb = {18'b0, r_ts};
            end
            default: begin
                n_ma = {{2{r_v[31]}}, r_v};
                n_mb = {18'b0, r_ts};
            end
        endcase
        n_mul = n_ma * n_mb;

        n_r2s  = {1'b0, r_r2} + {1'b0, r_prod[63:0]};
        n_cube = {1'b0, r_cacc} + {17'b0, r_prod[63:16]};
        n_mag  = (du_res > 65'h1_0000_0000) ? 33'h1_0000_0000 : du_res[32:0];
        n_fsum = 56'(r_f[r_ax]) + (n_dax[32] ? $signed({23'b0, n_mag})
                                             : -$signed({23'b0, n_mag}));
        n_vsum = 56'(n_vax) + 56'($signed(r_prod[67:16]));
        n_vnew = ngs_pkg::sat32(n_vsum);
        n_psum = 56'(n_pax) + 56'($signed(r_prod[67:16]));

        n_j1 = {1'b0, r_j} + (IW+1)'(1);
        n_j2 = (n_j1[IW-1:0] == r_i && n_j1 < (IW+1)'(BODIES)) ?
               n_j1 + (IW+1)'(1) : n_j1;
        n_iext = (IW+2)'(r_i);
        n_lidx = IW'(i_body);
    end

    assign du_req.go      = r_go;
    assign du_req.is_sqrt = r_is_sqrt;

    ngs_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .i_opa   (r_is_sqrt ? {r_r2, 1'b0} : r_prod[64:0]),
        .i_den   (r_den),
        .o_done  (du_done),
        .o_res   (du_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ngs_pkg::S_IDLE;
            r_go      <= 1'b0;
            r_is_sqrt <= 1'b0;
            r_strobe  <= 1'b0;
            r_emit    <= 1'b0;
            r_gain    <= ngs_pkg::GAIN_RST;
            r_ts      <= ngs_pkg::STEP_RST;
            r_soft    <= ngs_pkg::SOFT_RST;
            r_i       <= '0;
            r_j       <= '0;
            r_ax      <= '0;
            for (int k = 0; k < BODIES; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
                r_wt[k]  <= '0;
            end
        end else begin
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ngs_pkg::CFG_GAIN: r_gain <= i_cfg_data[15:0];
                    ngs_pkg::CFG_STEP: r_ts   <= i_cfg_data[15:0];
                    ngs_pkg::CFG_SOFT: r_soft <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_emit) begin
                r_strobe     <= 1'b1;
                r_obody      <= n_iext[1:0];
                r_ovec       <= r_np[r_i];
                r_olast      <= (r_i == ILAST);
                r_pos[r_i]   <= r_np[r_i];
                if (r_i == ILAST) begin
                    r_emit <= 1'b0;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end
            case (r_state)
                ngs_pkg::S_IDLE: begin
                    if (start && !r_emit) begin
                        if (i_mode == ngs_pkg::MODE_TICK) begin
                            r_state <= ngs_pkg::S_RDI;
                            r_i     <= '0;
                            r_j     <= IW'(1);
                            r_ax    <= '0;
                            r_r2    <= '0;
                            r_f     <= '{default: '0};
                        end else if (32'(i_body) < BODIES) begin
                            r_pos[n_lidx] <= {i_load_z, i_load_y, i_load_x};
                            r_vel[n_lidx] <= {i_load_vz, i_load_vy, i_load_vx};
                            r_wt[n_lidx]  <= i_load_mass;
                        end
                    end
                end
                ngs_pkg::S_RDI: begin
                    r_tmp   <= n_pax;
                    r_state <= ngs_pkg::S_RDJ;
                end
                ngs_pkg::S_RDJ: begin
                    r_d[r_ax] <= 33'(r_tmp) - 33'(n_pax);
                    r_state   <= ngs_pkg::S_SQR;
                end
                ngs_pkg::S_SQR: begin
                    r_prod  <= n_mul;
                    r_state <= ngs_pkg::S_ACC;
                end
                ngs_pkg::S_ACC: begin
                    r_r2 <= n_r2s[64] ? '1 : n_r2s[63:0];
                    if (r_ax == 2'd2) begin
                        r_ax      <= '0;
                        r_go      <= 1'b1;
                        r_is_sqrt <= 1'b1;
                        r_state   <= ngs_pkg::S_SQRT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= ngs_pkg::S_RDI;
                    end
                end
                ngs_pkg::S_SQRT: begin
                    if (du_done) begin
                        r_r     <= du_res[31:0];
                        r_state <= ngs_pkg::S_RMUL;
                    end
                end
                ngs_pkg::S_RMUL: begin
                    r_prod  <= n_mul;
                    r_state <= ngs_pkg::S_CMULH;
                end
                ngs_pkg::S_CMULH: begin
                    r_sl    <= r_prod[31:16];
                    r_prod  <= n_mul;
                    r_state <= ngs_pkg::S_CMULL;
                end
                ngs_pkg::S_CMULL: begin
                    r_cacc  <= r_prod[63:0];
                    r_prod  <= n_mul;
                    r_state <= ngs_pkg::S_CUBE;
                end
                ngs_pkg::S_CUBE: begin
                    r_cube  <= (n_cube[64:63] != 2'b00) ? '1 : n_cube[62:0];
                    r_state <= ngs_pkg::S_DEN;
                end
                ngs_pkg::S_DEN: begin
                    r_den   <= {1'b0, r_cube} + {33'b0, r_soft};
                    r_state <= ngs_pkg::S_GM;
                end
                ngs_pkg::S_GM: begin
                    r_gm    <= n_mul[31:0];
                    r_state <= (r_den == '0) ? ngs_pkg::S_NEXTJ : ngs_pkg::S_NUM;
                end
                ngs_pkg::S_NUM: begin
                    r_prod    <= n_mul;
                    r_go      <= 1'b1;
                    r_is_sqrt <= 1'b0;
                    r_state   <= ngs_pkg::S_DIV;
                end
                ngs_pkg::S_DIV: begin
                    if (du_done) begin
                        r_state <= ngs_pkg::S_FACC;
                    end
                end
                ngs_pkg::S_FACC: begin
                    r_f[r_ax] <= ngs_pkg::sat32(n_fsum);
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_state <= ngs_pkg::S_NEXTJ;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= ngs_pkg::S_NUM;
                    end
                end
                ngs_pkg::S_NEXTJ: begin
                    r_ax <= '0;
                    r_r2 <= '0;
                    if (n_j2 >= (IW+1)'(BODIES)) begin
                        r_state <= ngs_pkg::S_VMUL;
                    end else begin
                        r_j     <= n_j2[IW-1:0];
                        r_state <= ngs_pkg::S_RDI;
                    end
                end
                ngs_pkg::S_VMUL: begin
                    r_prod  <= n_mul;
                    r_state <= ngs_pkg::S_VADD;
                end
                ngs_pkg::S_VADD: begin
                    r_vel[r_i] <= ngs_pkg::axis_put(r_vel[r_i], r_ax, n_vnew);
                    r_v        <= n_vnew;
                    r_state    <= ngs_pkg::S_PMUL;
                end
                ngs_pkg::S_PMUL: begin
                    r_prod  <= n_mul;
                    r_state <= ngs_pkg::S_PADD;
                end
                ngs_pkg::S_PADD: begin
                    r_np[r_i] <= ngs_pkg::axis_put(r_np[r_i], r_ax,
                                                   ngs_pkg::sat32(n_psum));
                    if (r_ax == 2'd2) begin
                        r_ax <= '0;
                        r_r2 <= '0;
                        r_f  <= '{default: '0};
                        if (r_i == ILAST) begin
                            r_i     <= '0;
                            r_emit  <= 1'b1;
                            r_state <= ngs_pkg::S_IDLE;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_j     <= '0;
                            r_state <= ngs_pkg::S_RDI;
                        end
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= ngs_pkg::S_VMUL;
                    end
                end
                default: r_state <= ngs_pkg::S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != ngs_pkg::S_IDLE) || r_emit;
    assign o_strobe    = r_strobe;
    assign o_out_body  = r_obody;
    assign o_new_x     = r_ovec[0];
    assign o_new_y     = r_ovec[1];
    assign o_new_z     = r_ovec[2];
    assign o_last_body = r_olast;

    `NGS_ASSERT_IMP(a_last_strobed, o_last_body && o_strobe, r_state == ngs_pkg::S_IDLE)
    `NGS_ASSERT_NXT(a_tick_busy, start && !busy && i_mode == ngs_pkg::MODE_TICK, busy)
    `NGS_ASSERT_NXT(a_emit_run, o_strobe && !o_last_body, o_strobe)
    `NGS_ASSERT_IMP(a_du_idle_go, r_go, r_state == ngs_pkg::S_SQRT || r_state == ngs_pkg::S_DIV)
endmodule
